/* rtl/ppta_pkg.sv */
package ppta_pkg;

	localparam int SecW   = 32;
	localparam int FracW  = 15;
	localparam int PerW   = 16;
	localparam int PhW    = 7;
	localparam int DivW   = 16;
	localparam int TickW  = 32;
	localparam int QuoW   = 24;
	localparam int ProdW  = 62;
	localparam int MulAW  = 31;

	// cells in the tick-count divider and in the remainder chain
	localparam int ChainAN   = 16;
	localparam int ChainBN   = 47;
	// remainder after this many cells is seconds mod divisor
	localparam int SplitCell = 32;

	localparam logic [PhW-1:0]   PhaseMax   = 7'd100;
	localparam logic [DivW-1:0]  TicksPerSec = 16'h8000;
	// floor(x/100) = (x * Recip100) >> RecipShift for x < 2^31
	localparam logic [MulAW-1:0] Recip100   = 31'd1374389535;
	localparam int               RecipShift = 37;

	typedef struct packed {
		logic [SecW-1:0]  sec;
		logic [FracW-1:0] frac;
		logic [PerW-1:0]  per;
		logic [PhW-1:0]   phase;
		logic             neg;
		logic             err;
	} ppta_a_side_t;

	typedef struct packed {
		logic [SecW-1:0]  sec;
		logic [FracW-1:0] frac;
		logic [DivW-1:0]  d;
		logic [DivW-1:0]  r32;
		logic [PhW-1:0]   phase;
		logic             neg;
		logic             err;
	} ppta_b_side_t;

endpackage

/* rtl/ppta_div_cell.sv */
module ppta_div_cell #(
	parameter int AccW  = 16,
	parameter int SideW = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_i,
	input  logic [ppta_pkg::DivW-1:0] rem_i,
	input  logic [ppta_pkg::DivW-1:0] div_i,
	input  logic [AccW-1:0]           acc_i,
	input  logic [SideW-1:0]          side_i,
	output logic                      valid_o,
	output logic [ppta_pkg::DivW-1:0] rem_o,
	output logic [ppta_pkg::DivW-1:0] div_o,
	output logic [AccW-1:0]           acc_o,
	output logic [SideW-1:0]          side_o
);
	import ppta_pkg::*;

	logic [DivW:0]   trial;
	logic [DivW:0]   diff;
	logic            ge;
	logic            valid_q;
	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] div_q;
	logic [AccW-1:0] acc_q;
	logic [SideW-1:0] side_q;

	// bring down one dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_i, acc_i[AccW-1]};
		diff  = trial - {1'b0, div_i};
		ge    = (trial >= {1'b0, div_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// advance the word to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
			div_q  <= div_i;
			acc_q  <= {acc_i[AccW-2:0], ge};
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign rem_o   = rem_q;
	assign div_o   = div_q;
	assign acc_o   = acc_q;
	assign side_o  = side_q;

endmodule

/* rtl/ppta_post.sv */
module ppta_post (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_i,
	input  ppta_pkg::ppta_b_side_t     side_i,
	input  logic [ppta_pkg::DivW-1:0]  r47_i,
	output logic                       valid_o,
	output logic [ppta_pkg::SecW-1:0]  next_seconds,
	output logic [ppta_pkg::FracW-1:0] next_fraction,
	output logic                       period_error
);
	import ppta_pkg::*;

	logic [22:0]       dp;
	logic [TickW-1:0]  tick_base;
	logic [QuoW-1:0]   quo;
	logic [MulAW-1:0]  ph;

	logic              v_s1, v_s2, v_s3, valid_q;
	logic [SecW-1:0]   sec_s1, sec_s2, sec_s3;
	logic [TickW-1:0]  tb_s1, tb_s2, ticks_s3;
	logic [MulAW-1:0]  a_s1;
	logic [ProdW-1:0]  prod_s2;
	logic [PhW-1:0]    ph_s1, ph_s2;
	logic              neg_s1, neg_s2;
	logic              err_s1, err_s2, err_s3;
	logic [SecW-1:0]   sec_q;
	logic [FracW-1:0]  frac_q;
	logic              err_q;

	// aligned tick count for the fractional period
	always_comb begin
		dp        = 23'(side_i.d) * 23'(side_i.phase);
		tick_base = 32'({side_i.r32, 15'b0}) + 32'(side_i.frac) + 32'(side_i.d)
			- 32'(r47_i);
		quo       = prod_s2[RecipShift+QuoW-1:RecipShift];
		ph        = neg_s2 ? MulAW'(quo) : MulAW'(quo) * MulAW'(ph_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= valid_i;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// base moment and the phase operand
			sec_s1 <= side_i.neg ? side_i.sec - 32'(side_i.r32)
				: side_i.sec + 32'(side_i.d) - 32'(side_i.r32);
			tb_s1  <= side_i.neg ? tick_base : '0;
			a_s1   <= side_i.neg ? MulAW'(dp) : {side_i.d, 15'b0};
			ph_s1  <= side_i.phase;
			neg_s1 <= side_i.neg;
			err_s1 <= side_i.err;
			// divide by 100 through the reciprocal
			prod_s2 <= ProdW'(a_s1) * ProdW'(Recip100);
			sec_s2  <= sec_s1;
			tb_s2   <= tb_s1;
			ph_s2   <= ph_s1;
			neg_s2  <= neg_s1;
			err_s2  <= err_s1;
			// add the phase ticks
			ticks_s3 <= tb_s2 + TickW'(ph);
			sec_s3   <= sec_s2;
			err_s3   <= err_s2;
			// fold whole seconds of ticks into the seconds
			sec_q  <= err_s3 ? '0 : sec_s3 + 32'(ticks_s3[TickW-1:FracW]);
			frac_q <= err_s3 ? '0 : ticks_s3[FracW-1:0];
			err_q  <= err_s3;
		end
	end

	assign valid_o       = valid_q;
	assign next_seconds  = sec_q;
	assign next_fraction = frac_q;
	assign period_error  = err_q;

endmodule

/* rtl/periodic_publish_time_aligner.sv */
// Pipeline from an accepted query word to its result word: 16 tick-count
// divider cells, 47 remainder cells, 4 phase/output stages.
// Throughput: one query word per cycle; the whole pipeline holds while the
// result word is stalled.
// Reset: arst_n clears all stage valid bits asynchronously; data is not reset.
module periodic_publish_time_aligner (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       query_valid,
	output logic                       query_stall,
	input  logic [ppta_pkg::SecW-1:0]  now_seconds,
	input  logic [ppta_pkg::FracW-1:0] now_fraction,
	input  logic signed [ppta_pkg::PerW-1:0] period,
	input  logic [ppta_pkg::PhW-1:0]   phase_percent,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [ppta_pkg::SecW-1:0]  next_seconds,
	output logic [ppta_pkg::FracW-1:0] next_fraction,
	output logic                       period_error
);
	import ppta_pkg::*;

	localparam int ASideW = $bits(ppta_a_side_t);
	localparam int BSideW = $bits(ppta_b_side_t);

	logic                en;
	logic [ChainAN:0]    a_valid;
	logic [DivW-1:0]     a_rem  [0:ChainAN];
	logic [DivW-1:0]     a_div  [0:ChainAN];
	logic [DivW-1:0]     a_acc  [0:ChainAN];
	ppta_a_side_t        a_side [0:ChainAN];
	logic [ChainBN:0]    b_valid;
	logic [DivW-1:0]     b_rem  [0:ChainBN];
	logic [DivW-1:0]     b_div  [0:ChainBN];
	logic [SecW+FracW-1:0] b_acc [0:ChainBN];
	ppta_b_side_t        b_side [0:ChainBN];

	// hold every stage while the result word waits
	assign en          = !(result_valid && result_stall);
	assign query_stall = !en;

	// feed the tick-count divider: 32768 / n
	always_comb begin
		a_valid[0]      = query_valid;
		a_rem[0]        = '0;
		a_div[0]        = (~period) + 16'd1;
		a_acc[0]        = TicksPerSec;
		a_side[0].sec   = now_seconds;
		a_side[0].frac  = now_fraction;
		a_side[0].per   = period;
		a_side[0].phase = (phase_percent > PhaseMax) ? PhaseMax : phase_percent;
		a_side[0].neg   = period[PerW-1];
		a_side[0].err   = (period == '0);
	end

	for (genvar k = 0; k < ChainAN; k++) begin : g_a
		ppta_div_cell #(.AccW(DivW), .SideW(ASideW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(a_valid[k]), .rem_i(a_rem[k]), .div_i(a_div[k]),
			.acc_i(a_acc[k]), .side_i(a_side[k]),
			.valid_o(a_valid[k+1]), .rem_o(a_rem[k+1]), .div_o(a_div[k+1]),
			.acc_o(a_acc[k+1]), .side_o(a_side[k+1])
		);
	end

	// pick the divisor and feed the remainder chain with seconds:fraction
	always_comb begin
		b_valid[0]      = a_valid[ChainAN];
		b_rem[0]        = '0;
		b_div[0]        = a_side[ChainAN].neg ? a_acc[ChainAN] : a_side[ChainAN].per;
		b_acc[0]        = {a_side[ChainAN].sec, a_side[ChainAN].frac};
		b_side[0].sec   = a_side[ChainAN].sec;
		b_side[0].frac  = a_side[ChainAN].frac;
		b_side[0].d     = b_div[0];
		b_side[0].r32   = '0;
		b_side[0].phase = a_side[ChainAN].phase;
		b_side[0].neg   = a_side[ChainAN].neg;
		b_side[0].err   = a_side[ChainAN].err;
	end

	for (genvar k = 0; k < ChainBN; k++) begin : g_b
		ppta_b_side_t s_in;

		// capture seconds mod divisor once all seconds bits are in
		always_comb begin
			s_in = b_side[k];
			if (k == SplitCell) begin
				s_in.r32 = b_rem[k];
			end
		end

		ppta_div_cell #(.AccW(SecW+FracW), .SideW(BSideW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(b_valid[k]), .rem_i(b_rem[k]), .div_i(b_div[k]),
			.acc_i(b_acc[k]), .side_i(s_in),
			.valid_o(b_valid[k+1]), .rem_o(b_rem[k+1]), .div_o(b_div[k+1]),
			.acc_o(b_acc[k+1]), .side_o(b_side[k+1])
		);
	end

	ppta_post u_post (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(b_valid[ChainBN]), .side_i(b_side[ChainBN]), .r47_i(b_rem[ChainBN]),
		.valid_o(result_valid), .next_seconds(next_seconds),
		.next_fraction(next_fraction), .period_error(period_error)
	);

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && period_error |-> next_seconds == '0 && next_fraction == '0)
		else $error("error result carries a nonzero moment");

	a_tick_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		a_valid[ChainAN] && a_side[ChainAN].neg |-> a_acc[ChainAN] != '0)
		else $error("tick period came out zero");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid[ChainBN] && !b_side[ChainBN].err |-> b_rem[ChainBN] < b_div[ChainBN])
		else $error("remainder not below divisor");
`endif

endmodule
